// ===== rtl/core/dma_protection_window_clipper_defines.svh =====
// ----------------------------------------------------------------------------
// dma_protection_window_clipper_defines.svh
// Assertion macros shared by the clipper checker.
// ----------------------------------------------------------------------------
`ifndef DMA_PROTECTION_WINDOW_CLIPPER_DEFINES_SVH
`define DMA_PROTECTION_WINDOW_CLIPPER_DEFINES_SVH

// Concurrent check, sampled on clk, off while reset is asserted.
`define DPWC_CHECK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dpwc check failed");

// Concurrent check that also holds while reset is asserted.
`define DPWC_CHECK_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("dpwc check failed");

`endif

// ===== rtl/core/dpwc_pkg.sv =====
// ----------------------------------------------------------------------------
// dpwc_pkg
// Widths, window base patterns and codes for the DMA protection window clipper.
// ----------------------------------------------------------------------------
package dpwc_pkg;

    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 12;
    localparam int BLOCK_W = 7;
    localparam int IDX_W   = 2;

    localparam logic [LEN_W-1:0] MAX_CHUNK_BYTES = 12'd2352;

    // window edges: block index sits in bits 26:20 over a fixed base
    localparam logic [ADDR_W-1:0] TOP_BASE = 32'h0800_0000;
    localparam logic [ADDR_W-1:0] BOT_BASE = 32'h080f_ffff;

    localparam logic OP_CHUNK       = 1'b0;
    localparam logic OP_QUEUE_EMPTY = 1'b1;

    typedef enum logic [IDX_W-1:0] {
        REG_PROT_TOP    = 2'd0,
        REG_PROT_BOTTOM = 2'd1,
        REG_START_ADDR  = 2'd2,
        REG_DMA_LENGTH  = 2'd3
    } cfg_reg_t;

endpackage

// ===== rtl/core/dma_protection_window_clipper.sv =====
// ----------------------------------------------------------------------------
// dma_protection_window_clipper
// Caps DMA chunks at the chunk limit, cuts them to the bytes owed and clips them to the protected window.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid/item_stall): one request per buffered chunk
//   (operation = chunk, chunk_length bytes) or an end-of-queue mark.
//   Result channel (result_valid/result_stall): exactly one result per
//   request: permitted write address/length, write_valid, and transfer_done
//   with final_count when the length is met or the queue runs empty.
//   A request passes from the input register through the clip logic into
//   the result register. Throughput is one request per cycle while the
//   receiver does not stall; running address and byte count update in the
//   same cycle a request leaves the input register, so back-to-back
//   requests see them.
//   When the receiver stalls, the result holds and one more request waits
//   in the input register; item_stall rises only when both are full.
//   Reset clears both stages, loads the window registers (top 127, bottom 0),
//   start address and length 0, and restarts the transfer state.
//   Configuration writes (cfg_write/cfg_index/cfg_data) take effect at the
//   next edge; writing the start address also restarts the transfer.
// ----------------------------------------------------------------------------
module dma_protection_window_clipper
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_write,
    input  logic [dpwc_pkg::IDX_W-1:0]    cfg_index,
    input  logic [dpwc_pkg::ADDR_W-1:0]   cfg_data,

    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          operation,
    input  logic [dpwc_pkg::LEN_W-1:0]    chunk_length,

    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [dpwc_pkg::ADDR_W-1:0]   write_address,
    output logic [dpwc_pkg::LEN_W-1:0]    write_length,
    output logic                          write_valid,
    output logic                          transfer_done,
    output logic [dpwc_pkg::ADDR_W-1:0]   final_count
);

    localparam int AW = dpwc_pkg::ADDR_W;
    localparam int LW = dpwc_pkg::LEN_W;
    localparam int BW = dpwc_pkg::BLOCK_W;

    // configuration
    logic [BW-1:0] prot_top_reg;
    logic [BW-1:0] prot_bot_reg;
    logic [AW-1:0] load_addr_reg;
    logic [AW-1:0] xfer_len_reg;

    // transfer state
    logic [AW-1:0] cur_addr_reg;
    logic [AW-1:0] bytes_reg;
    logic [AW-1:0] cur_addr_next;
    logic [AW-1:0] bytes_next;

    // input stage
    logic          in_vld_reg;
    logic          in_op_reg;
    logic [LW-1:0] in_len_reg;

    // result stage
    logic          out_vld_reg;
    logic [AW-1:0] out_addr_reg;
    logic [LW-1:0] out_len_reg;
    logic          out_wvld_reg;
    logic          out_done_reg;
    logic [AW-1:0] out_count_reg;

    logic out_free;
    logic advance;

    assign out_free   = !out_vld_reg || !result_stall;
    assign advance    = in_vld_reg && out_free;
    assign item_stall = in_vld_reg && !out_free;

    // ---------------- clip logic ----------------
    logic          active;
    logic [AW-1:0] owed;
    logic [LW-1:0] capped;
    logic [LW-1:0] size0;
    logic [AW-1:0] win_top;
    logic [AW-1:0] win_bot;
    logic [AW:0]   end_sum;
    logic          below;
    logic          skip;
    logic [AW-1:0] gap;
    logic [AW-1:0] addr1;
    logic [LW-1:0] size1;
    logic [AW:0]   last_sum;
    logic [AW-1:0] bot_room;
    logic [LW-1:0] size2;
    logic [LW-1:0] adv_size;
    logic          wr_ok;
    logic          done;
    logic [AW-1:0] counted;

    always_comb
    begin
        active  = (in_op_reg == dpwc_pkg::OP_CHUNK) && (bytes_reg < xfer_len_reg);
        owed    = xfer_len_reg - bytes_reg;
        capped  = (in_len_reg > dpwc_pkg::MAX_CHUNK_BYTES) ? dpwc_pkg::MAX_CHUNK_BYTES
                                                           : in_len_reg;
        size0   = (owed < {{(AW-LW){1'b0}}, capped}) ? owed[LW-1:0] : capped;
        counted = bytes_reg + {{(AW-LW){1'b0}}, size0};

        win_top = dpwc_pkg::TOP_BASE | {{(AW-BW-20){1'b0}}, prot_top_reg, 20'h0_0000};
        win_bot = dpwc_pkg::BOT_BASE | {{(AW-BW-20){1'b0}}, prot_bot_reg, 20'h0_0000};

        // lying wholly below the top is skipped, straddling starts at the top
        end_sum = {1'b0, cur_addr_reg} + {{(AW+1-LW){1'b0}}, size0};
        below   = cur_addr_reg < win_top;
        skip    = below && (end_sum < {1'b0, win_top});
        gap     = win_top - cur_addr_reg;
        if (below && !skip)
        begin
            addr1 = win_top;
            size1 = size0 - gap[LW-1:0];
        end
        else
        begin
            addr1 = cur_addr_reg;
            size1 = size0;
        end

        // clip to end at the bottom
        last_sum = {1'b0, addr1} + {{(AW+1-LW){1'b0}}, size1} - {{AW{1'b0}}, 1'b1};
        bot_room = win_bot - addr1 + {{(AW-1){1'b0}}, 1'b1};
        if (size1 == '0 || addr1 > win_bot)
            size2 = '0;
        else if (last_sum > {1'b0, win_bot})
            size2 = bot_room[LW-1:0];
        else
            size2 = size1;

        adv_size = skip ? size0 : size2;
        wr_ok    = active && !skip && (size2 != '0);
        done     = !active || (counted >= xfer_len_reg);

        cur_addr_next = cur_addr_reg;
        bytes_next    = bytes_reg;
        if (advance)
        begin
            if (done)
            begin
                cur_addr_next = load_addr_reg;
                bytes_next    = '0;
            end
            else
            begin
                cur_addr_next = addr1 + {{(AW-LW){1'b0}}, adv_size};
                bytes_next    = counted;
            end
        end

        // writing the start address restarts the transfer
        if (cfg_write && cfg_index == dpwc_pkg::REG_START_ADDR)
        begin
            cur_addr_next = cfg_data;
            bytes_next    = '0;
        end
    end

    // ---------------- control and state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prot_top_reg  <= '1;
            prot_bot_reg  <= '0;
            load_addr_reg <= '0;
            xfer_len_reg  <= '0;
            cur_addr_reg  <= '0;
            bytes_reg     <= '0;
            in_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            cur_addr_reg <= cur_addr_next;
            bytes_reg    <= bytes_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    dpwc_pkg::REG_PROT_TOP:    prot_top_reg  <= cfg_data[BW-1:0];
                    dpwc_pkg::REG_PROT_BOTTOM: prot_bot_reg  <= cfg_data[BW-1:0];
                    dpwc_pkg::REG_START_ADDR:  load_addr_reg <= cfg_data;
                    dpwc_pkg::REG_DMA_LENGTH:  xfer_len_reg  <= cfg_data;
                    default: ;
                endcase
            end

            if (item_valid && !item_stall)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;

            if (advance)
                out_vld_reg <= 1'b1;
            else if (!result_stall)
                out_vld_reg <= 1'b0;
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_op_reg  <= operation;
            in_len_reg <= chunk_length;
        end
        if (advance)
        begin
            out_wvld_reg  <= wr_ok;
            out_addr_reg  <= wr_ok ? addr1 : '0;
            out_len_reg   <= wr_ok ? size2 : '0;
            out_done_reg  <= done;
            out_count_reg <= !done ? '0 : (active ? counted : bytes_reg);
        end
    end

    assign result_valid  = out_vld_reg;
    assign write_address = out_addr_reg;
    assign write_length  = out_len_reg;
    assign write_valid   = out_wvld_reg;
    assign transfer_done = out_done_reg;
    assign final_count   = out_count_reg;

endmodule

// ===== rtl/core/dpwc_checker.sv =====
// ----------------------------------------------------------------------------
// dpwc_checker
// Port-level checks for the DMA protection window clipper, bound to the top.
// ----------------------------------------------------------------------------
`include "dma_protection_window_clipper_defines.svh"

module dpwc_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_stall,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  logic [dpwc_pkg::ADDR_W-1:0]   write_address,
    input  logic [dpwc_pkg::LEN_W-1:0]    write_length,
    input  logic                          write_valid,
    input  logic                          transfer_done,
    input  logic [dpwc_pkg::ADDR_W-1:0]   final_count
);

    // a stalled result keeps its request
    `DPWC_CHECK(a_result_hold, result_valid && result_stall |=> result_valid && $stable(write_address) && $stable(write_length) && $stable(final_count))

    // skipped chunks report zero address and length
    `DPWC_CHECK(a_skip_zero, result_valid && !write_valid |-> write_address == '0 && write_length == '0)

    // a permitted write is never empty and never above the chunk cap
    `DPWC_CHECK(a_write_len, result_valid && write_valid |-> write_length != '0 && write_length <= dpwc_pkg::MAX_CHUNK_BYTES)

    // count reported only at transfer end
    `DPWC_CHECK(a_count_done, result_valid && !transfer_done |-> final_count == '0)

    // input side backs up only while a result is held
    `DPWC_CHECK_ALWAYS(a_stall_cause, item_stall |-> result_valid && result_stall)

endmodule

bind dma_protection_window_clipper dpwc_checker u_dpwc_checker (.*);
